// ===== hdl/mtk_pkg.sv =====
// ----------------------------------------------------------------------------
// mtk_pkg
// Shared types, key codes, letter-group tables and result layout for the
// multi-tap keypad text entry block.
// ----------------------------------------------------------------------------
package mtk_pkg;

    localparam int TEXT_CAPACITY_DEFAULT = 32;

    localparam logic [7:0] KEY_BACKSPACE = 8'd16;
    localparam logic [7:0] KEY_ENTER     = 8'd17;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_WINDOW = 2'd1;

    localparam logic [31:0] MIN_GAP_RESET    = 32'd100000;
    localparam logic [31:0] TAP_WINDOW_RESET = 32'd1000000;

    localparam int GROUP_COUNT = 16;
    localparam int GROUP_MAX   = 5;

    typedef enum logic [2:0] {
        ACT_IGNORED  = 3'd0,
        ACT_REPLACED = 3'd1,
        ACT_APPENDED = 3'd2,
        ACT_DELETED  = 3'd3,
        ACT_DONE     = 3'd4,
        ACT_REJECTED = 3'd5
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [4:0]  edit_position;
        logic [7:0]  written_char;
        logic [4:0]  text_length;
    } result_t;

    localparam logic [2:0] GROUP_LEN [GROUP_COUNT] = '{
        3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5,
        3'd4, 3'd5, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    localparam logic [7:0] GROUP_CHARS [GROUP_COUNT][GROUP_MAX] = '{
        '{"0", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"1", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"2", "a", "b", "c", 8'd0},
        '{"3", "d", "e", "f", 8'd0},
        '{"4", "g", "h", "i", 8'd0},
        '{"5", "j", "k", "l", 8'd0},
        '{"6", "m", "n", "o", 8'd0},
        '{"7", "p", "q", "r", "s"},
        '{"8", "t", "u", "v", 8'd0},
        '{"9", "w", "x", "y", "z"},
        '{"+", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"-", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"*", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"/", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"x", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"y", 8'd0, 8'd0, 8'd0, 8'd0}
    };

    function automatic logic [7:0] group_char(input logic [3:0] group,
                                              input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'd0;
        if (idx < 3'(GROUP_MAX))
        begin
            ch = GROUP_CHARS[group][idx];
        end
        return ch;
    endfunction

endpackage

// ===== hdl/mtk_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mtk_cfg_regs
// Configuration registers: minimum press gap and tap window, in ticks.
// ----------------------------------------------------------------------------
module mtk_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data,
    output logic [31:0]                      min_gap,
    output logic [31:0]                      tap_window
);

    logic [31:0] min_gap_reg;
    logic [31:0] tap_window_reg;

    assign cfg_ready  = 1'b1;
    assign min_gap    = min_gap_reg;
    assign tap_window = tap_window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg    <= mtk_pkg::MIN_GAP_RESET;
            tap_window_reg <= mtk_pkg::TAP_WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == mtk_pkg::CFG_MIN_GAP)
            begin
                min_gap_reg <= cfg_data;
            end
            else if (cfg_index == mtk_pkg::CFG_TAP_WINDOW)
            begin
                tap_window_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hdl/mtk_step.sv =====
// ----------------------------------------------------------------------------
// mtk_step
// Decision logic for one key press: gap test, key decode, repeat test and
// letter lookup, giving the result and the next editor state.
// ----------------------------------------------------------------------------
module mtk_step #(
    parameter int TEXT_CAPACITY = mtk_pkg::TEXT_CAPACITY_DEFAULT,
    localparam int CUR_W = $clog2(TEXT_CAPACITY)
) (
    input  logic [7:0]        key_code,
    input  logic [31:0]       press_time,
    input  logic [CUR_W-1:0]  cursor,
    input  logic [2:0]        tap_index,
    input  logic [4:0]        last_key,
    input  logic [31:0]       last_time,
    input  logic [31:0]       min_gap,
    input  logic [31:0]       tap_window,
    output mtk_pkg::result_t  result,
    output logic              update,
    output logic [CUR_W-1:0]  cursor_next,
    output logic [2:0]        tap_next,
    output logic [4:0]        key_next
);

    logic [31:0]       elapsed;
    logic              too_close;
    logic              repeat_tap;
    logic              full;
    logic [2:0]        tap_inc;
    logic [2:0]        grp_len;
    logic [CUR_W-1:0]  cursor_dec;
    logic [CUR_W-1:0]  pos;
    logic [CUR_W+4:0]  pos_ext;
    logic [CUR_W+4:0]  len_ext;
    mtk_pkg::action_t  act;
    logic [7:0]        wchar;

    assign elapsed    = press_time - last_time;
    assign too_close  = elapsed < min_gap;
    assign repeat_tap = (cursor != '0) && (key_code == {3'd0, last_key})
                        && (elapsed <= tap_window);
    assign full       = cursor == CUR_W'(TEXT_CAPACITY - 1);
    assign grp_len    = mtk_pkg::GROUP_LEN[key_code[3:0]];
    assign tap_inc    = (tap_index + 3'd1 < grp_len) ? tap_index + 3'd1 : 3'd0;
    assign cursor_dec = (cursor != '0) ? cursor - 1'b1 : '0;

    always_comb
    begin
        act         = mtk_pkg::ACT_IGNORED;
        wchar       = 8'd0;
        pos         = cursor;
        update      = 1'b0;
        cursor_next = cursor;
        tap_next    = tap_index;
        key_next    = last_key;
        priority if (key_code == mtk_pkg::KEY_ENTER)
        begin
            act = mtk_pkg::ACT_DONE;
        end
        else if (too_close)
        begin
            act = mtk_pkg::ACT_IGNORED;
        end
        else if (key_code > mtk_pkg::KEY_ENTER)
        begin
            act = mtk_pkg::ACT_REJECTED;
        end
        else if (key_code == mtk_pkg::KEY_BACKSPACE)
        begin
            act         = mtk_pkg::ACT_DELETED;
            pos         = cursor_dec;
            update      = 1'b1;
            cursor_next = cursor_dec;
            tap_next    = 3'd0;
            key_next    = key_code[4:0];
        end
        else if (repeat_tap)
        begin
            act      = mtk_pkg::ACT_REPLACED;
            wchar    = mtk_pkg::group_char(key_code[3:0], tap_inc);
            pos      = cursor - 1'b1;
            update   = 1'b1;
            tap_next = tap_inc;
        end
        else if (full)
        begin
            act = mtk_pkg::ACT_REJECTED;
        end
        else
        begin
            act         = mtk_pkg::ACT_APPENDED;
            wchar       = mtk_pkg::group_char(key_code[3:0], 3'd0);
            update      = 1'b1;
            cursor_next = cursor + 1'b1;
            tap_next    = 3'd0;
            key_next    = key_code[4:0];
        end
    end

    assign pos_ext = {5'd0, pos};
    assign len_ext = {5'd0, cursor_next};
    assign result  = {act, pos_ext[4:0], wchar, len_ext[4:0]};

endmodule

// ===== hdl/multitap_keypad_text_entry.sv =====
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry
// Multi-tap text entry from timestamped key presses. Each press yields one
// result naming the edit made; the text itself is rebuilt downstream from
// the stream of positions and characters.
//
//   channel   signals                                    direction
//   in        in_valid/in_ready, key_code, press_time    into block
//   out       out_valid/out_ready, action, edit_position,
//             written_char, text_length                  out of block
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data   into block
//
// One press per cycle sustained while out_ready allows; a press goes from the
// input register through the single decision pass on the editor state to the result register.
// Reset clears the editor state and loads the configuration defaults; no
// clearing pass is needed. A stalled result holds the input register, and
// the input side stalls only when both registers are full.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry #(
    parameter int TEXT_CAPACITY = mtk_pkg::TEXT_CAPACITY_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       key_code,
    input  logic [31:0]                      press_time,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       action,
    output logic [4:0]                       edit_position,
    output logic [7:0]                       written_char,
    output logic [4:0]                       text_length,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int CUR_W = $clog2(TEXT_CAPACITY);

    logic [31:0]       min_gap;
    logic [31:0]       tap_window;

    logic              s1_valid_reg;
    logic [7:0]        s1_key_reg;
    logic [31:0]       s1_time_reg;
    logic              out_valid_reg;
    mtk_pkg::result_t  result_reg;

    logic [CUR_W-1:0]  cursor_reg;
    logic [2:0]        tap_index_reg;
    logic [4:0]        last_key_reg;
    logic [31:0]       last_time_reg;

    mtk_pkg::result_t  result_next;
    logic              update;
    logic [CUR_W-1:0]  cursor_next;
    logic [2:0]        tap_next;
    logic [4:0]        key_next;
    logic              advance;

    mtk_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .min_gap    (min_gap),
        .tap_window (tap_window)
    );

    mtk_step #(
        .TEXT_CAPACITY (TEXT_CAPACITY)
    ) u_step (
        .key_code    (s1_key_reg),
        .press_time  (s1_time_reg),
        .cursor      (cursor_reg),
        .tap_index   (tap_index_reg),
        .last_key    (last_key_reg),
        .last_time   (last_time_reg),
        .min_gap     (min_gap),
        .tap_window  (tap_window),
        .result      (result_next),
        .update      (update),
        .cursor_next (cursor_next),
        .tap_next    (tap_next),
        .key_next    (key_next)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cursor_reg    <= '0;
            tap_index_reg <= 3'd0;
            last_key_reg  <= 5'd0;
            last_time_reg <= 32'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && update)
            begin
                cursor_reg    <= cursor_next;
                tap_index_reg <= tap_next;
                last_key_reg  <= key_next;
                last_time_reg <= s1_time_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_key_reg  <= key_code;
            s1_time_reg <= press_time;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = result_reg.action;
    assign edit_position = result_reg.edit_position;
    assign written_char  = result_reg.written_char;
    assign text_length   = result_reg.text_length;

endmodule

// ===== hdl/mtk_checker.sv =====
// ----------------------------------------------------------------------------
// mtk_checker
// Port-level checks on the result stream of the text entry block, bound to
// the top level.
// ----------------------------------------------------------------------------
module mtk_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  action,
    input  logic [4:0]  edit_position,
    input  logic [7:0]  written_char,
    input  logic [4:0]  text_length
);

    localparam logic [2:0] A_IGNORED  = 3'(mtk_pkg::ACT_IGNORED);
    localparam logic [2:0] A_REPLACED = 3'(mtk_pkg::ACT_REPLACED);
    localparam logic [2:0] A_APPENDED = 3'(mtk_pkg::ACT_APPENDED);
    localparam logic [2:0] A_DELETED  = 3'(mtk_pkg::ACT_DELETED);
    localparam logic [2:0] A_DONE     = 3'(mtk_pkg::ACT_DONE);
    localparam logic [2:0] A_REJECTED = 3'(mtk_pkg::ACT_REJECTED);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action)
            && $stable(text_length) && $stable(edit_position))
        else $error("stalled result changed");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == A_APPENDED |->
            text_length == edit_position + 5'd1 && written_char != 8'd0)
        else $error("append not at end of text");

    a_replace: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == A_REPLACED |->
            text_length == edit_position + 5'd1 && written_char != 8'd0)
        else $error("replace not on last character");

    a_delete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == A_DELETED |->
            text_length == edit_position && written_char == 8'd0)
        else $error("delete did not leave terminator at end");

    a_noedit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == A_IGNORED || action == A_DONE
            || action == A_REJECTED) |->
            edit_position == text_length && written_char == 8'd0)
        else $error("no-edit result carries an edit");

endmodule

bind multitap_keypad_text_entry mtk_checker u_mtk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .edit_position (edit_position),
    .written_char  (written_char),
    .text_length   (text_length)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-tap keypad text entry block. A local
// editor model predicts the action, position, character and text length
// of every press; each result transaction is checked in order against it.
// Directed presses cover the group cycling, gap and window edges, timestamp
// wrap, backspace on empty and a full text. Random presses follow under
// several timing settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mtk_pkg::*;

    localparam int TEXT_CAP     = TEXT_CAPACITY_DEFAULT;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int CHUNK_PRESSES = 144;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [7:0]             key_code      = 8'd0;
    logic [31:0]            press_time    = 32'd0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [2:0]             action;
    logic [4:0]             edit_position;
    logic [7:0]             written_char;
    logic [4:0]             text_length;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [31:0]            cfg_data      = 32'd0;

    // editor model
    logic [31:0] gap_ticks    = MIN_GAP_RESET;
    logic [31:0] window_ticks = TAP_WINDOW_RESET;
    int          text_len     = 0;
    int          tap_pos      = 0;
    logic [7:0]  prev_key     = 8'd0;
    logic [31:0] prev_press   = 32'd0;

    result_t expected_edits[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   bs_pct        = 8;
    int   mismatches    = 0;
    int   idle_cycles   = 0;
    bit   hold_active   = 1'b0;
    event hold_start;

    multitap_keypad_text_entry u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_code      (key_code),
        .press_time    (press_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .edit_position (edit_position),
        .written_char  (written_char),
        .text_length   (text_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic string letter_group(input logic [3:0] grp);
        case (grp)
            4'd0:    return "0";
            4'd1:    return "1";
            4'd2:    return "2abc";
            4'd3:    return "3def";
            4'd4:    return "4ghi";
            4'd5:    return "5jkl";
            4'd6:    return "6mno";
            4'd7:    return "7pqrs";
            4'd8:    return "8tuv";
            4'd9:    return "9wxyz";
            4'd10:   return "+";
            4'd11:   return "-";
            4'd12:   return "*";
            4'd13:   return "/";
            4'd14:   return "x";
            default: return "y";
        endcase
    endfunction

    function automatic result_t predict_edit(input logic [7:0] k, input logic [31:0] t);
        logic [31:0] elapsed;
        string       grp;
        result_t     r;
        elapsed         = t - prev_press;
        r.action        = ACT_DONE;
        r.edit_position = 5'(text_len);
        r.written_char  = 8'd0;
        if (k == KEY_ENTER)
        begin
            r.action = ACT_DONE;
        end
        else if (elapsed < gap_ticks)
        begin
            r.action = ACT_IGNORED;
        end
        else if (k > KEY_ENTER)
        begin
            r.action = ACT_REJECTED;
        end
        else if (k == KEY_BACKSPACE)
        begin
            if (text_len != 0)
                text_len--;
            tap_pos         = 0;
            prev_key        = k;
            prev_press      = t;
            r.action        = ACT_DELETED;
            r.edit_position = 5'(text_len);
        end
        else if (text_len != 0 && k == prev_key && elapsed <= window_ticks)
        begin
            grp             = letter_group(k[3:0]);
            tap_pos         = (tap_pos + 1 < grp.len()) ? tap_pos + 1 : 0;
            prev_press      = t;
            r.action        = ACT_REPLACED;
            r.edit_position = 5'(text_len - 1);
            r.written_char  = grp[tap_pos];
        end
        else if (text_len >= TEXT_CAP - 1)
        begin
            r.action = ACT_REJECTED;
        end
        else
        begin
            grp             = letter_group(k[3:0]);
            r.action        = ACT_APPENDED;
            r.edit_position = 5'(text_len);
            r.written_char  = grp[0];
            text_len++;
            tap_pos         = 0;
            prev_key        = k;
            prev_press      = t;
        end
        r.text_length = 5'(text_len);
        return r;
    endfunction

    // call at a falling edge; returns at a falling edge with valid still high
    task automatic send_press(input logic [7:0] k, input logic [31:0] t);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        key_code   <= k;
        press_time <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_edit(k, t);
        expected_edits.push_back(r);
        @(negedge clk);
    endtask

    task automatic press_key(input logic [7:0] k, input logic [31:0] delta);
        send_press(k, prev_press + delta);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_edits.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MIN_GAP)
            gap_ticks = value;
        else
            window_ticks = value;
        @(negedge clk);
    endtask

    task automatic set_timing(input logic [31:0] gap, input logic [31:0] window);
        write_register(CFG_MIN_GAP, gap);
        write_register(CFG_TAP_WINDOW, window);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < bs_pct)
            return KEY_BACKSPACE;
        if (roll < bs_pct + 5)
            return KEY_ENTER;
        if (roll < bs_pct + 10)
            return 8'($urandom_range(255, 18));
        if (roll < bs_pct + 50 && prev_key < KEY_BACKSPACE)
            return prev_key;
        return 8'($urandom_range(15));
    endfunction

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(9))
            0:       return (gap_ticks == 0) ? 32'd0 : 32'($urandom_range(gap_ticks - 1));
            1:       return gap_ticks;
            2:       return window_ticks;
            3:       return window_ticks + 32'd1;
            4:       return $urandom;
            default:
            begin
                if (window_ticks > gap_ticks)
                    return gap_ticks + 32'($urandom_range(window_ticks - gap_ticks));
                return gap_ticks + 32'($urandom_range(1000));
            end
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        press_key(8'd5, 32'd17);
        press_key(KEY_ENTER, 32'd0);
        press_key(KEY_BACKSPACE, 32'd100000);
        press_key(8'd2, 32'd100000);
        press_key(8'd2, 32'd99999);
        press_key(8'd2, 32'd1000000);
        press_key(8'd2, 32'd200000);
        press_key(8'd2, 32'd200000);
        press_key(8'd2, 32'd200000);
        press_key(8'd2, 32'd1000001);
        for (int i = 0; i < 6; i++)
            press_key(8'd7, 32'd150000);
        press_key(8'd0, 32'd100000);
        press_key(8'd0, 32'd100000);
        press_key(8'd15, 32'd100000);
        press_key(8'd255, 32'd100000);
        press_key(8'd18, 32'd100000);
        press_key(KEY_BACKSPACE, 32'd100000);
        press_key(8'd15, 32'd100000);
        press_key(8'd3, 32'hFFFF0000);
        press_key(8'd3, 32'd200000);
    endtask

    task automatic test_full_text();
        while (text_len != 0)
            press_key(KEY_BACKSPACE, 32'd100000);
        for (int i = 0; i < TEXT_CAP - 1; i++)
            press_key((i % 2) ? 8'd5 : 8'd4, 32'd100000);
        press_key(8'd6, 32'd100000);
        press_key(prev_key, 32'd100000);
        press_key(KEY_BACKSPACE, 32'd100000);
    endtask

    task automatic test_config_limits();
        wait_drain();
        set_timing(32'd0, 32'd0);
        press_key(8'd8, 32'd0);
        press_key(8'd8, 32'd0);
        press_key(8'd8, 32'd1);
        wait_drain();
        set_timing(32'hFFFFFFFF, 32'hFFFFFFFF);
        press_key(8'd1, 32'hFFFFFFFE);
        press_key(8'd1, 32'hFFFFFFFF);
        press_key(8'd1, 32'hFFFFFFFF);
        press_key(KEY_ENTER, 32'd3);
        wait_drain();
        set_timing(MIN_GAP_RESET, TAP_WINDOW_RESET);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_start;
        for (int i = 0; i < 40; i++)
            press_key(pick_key(), pick_delta());
        wait_drain();
        for (int i = 0; i < 20; i++)
            press_key(pick_key(), pick_delta());
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            wait_drain();
            case (chunk)
                0:       set_timing($urandom_range(1000), $urandom_range(100000, 2000));
                1:       set_timing(32'd0, 32'd0);
                2:       set_timing(32'hFFFFFFFF, 32'hFFFFFFFF);
                default: set_timing(32'd0, 32'hFFFFFFFF);
            endcase
            bs_pct = (chunk % 2) ? 35 : 8;
            for (int i = 0; i < CHUNK_PRESSES; i++)
                press_key(pick_key(), pick_delta());
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always
    begin
        @(hold_start);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
    end

    always @(negedge clk)
        out_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_edits.size() == 0)
            begin
                $display("%0t: result expected none, actual action %0d pos %0d",
                         $time, action, edit_position);
                mismatches++;
            end
            else
            begin
                want = expected_edits.pop_front();
                check_field("action", want.action, action);
                check_field("edit_position", want.edit_position, edit_position);
                check_field("written_char", want.written_char, written_char);
                check_field("text_length", want.text_length, text_length);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_full_text();
        test_config_limits();
        test_backpressure();
        test_random_traffic(34, 86);
        test_random_traffic(86, 34);
        test_random_traffic(0, 0);
        wait_drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_edits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== multitap_keypad_text_entry.f =====
hdl/mtk_pkg.sv
hdl/mtk_cfg_regs.sv
hdl/mtk_step.sv
hdl/multitap_keypad_text_entry.sv
hdl/mtk_checker.sv
test/tb.sv
